// File: src/matrix_column_dedup_assert.svh
// assertion macros for the duplicate column elimination block
// no dependencies; expects clk and arst_n in the including scope
`ifndef MATRIX_COLUMN_DEDUP_ASSERT_SVH
`define MATRIX_COLUMN_DEDUP_ASSERT_SVH
`ifndef SYNTHESIS
`define MCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MCD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MCD_ASSERT(lbl, prop, msg)
`define MCD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: src/mcd_pkg.sv
// shared types and constants for the duplicate column elimination block
// no dependencies
package mcd_pkg;
	localparam int ROW_COUNT_W = 7;
	localparam int COL_COUNT_W = 9;
	localparam int CFG_DATA_W  = 9;

	localparam logic CFG_ROW_COUNT = 1'b0;
	localparam logic CFG_COL_COUNT = 1'b1;

	typedef struct packed {
		logic [7:0] group_id;
		logic       is_new;
		logic [8:0] distinct_count;
		logic       overflow;
		logic       matrix_done;
	} mcd_result_t;
endpackage

// File: src/mcd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/mcd_queue.sv
// short register queue between front and back
// no dependencies
module mcd_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

// File: src/mcd_front.sv
// front end: takes state ids, tracks the row and marks the last item of a column
// depends on mcd_pkg
module mcd_front import mcd_pkg::*; #(
	parameter int MAX_ROWS   = 64,
	parameter int STATE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ROW_COUNT_W-1:0] row_count,
	input  logic                   push,
	input  logic [15:0]            state_id,
	output logic [STATE_BITS-1:0]  elem,
	output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] row,
	output logic                   last,
	output logic [$clog2(MAX_ROWS + 1)-1:0] rows
);
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int XW  = (RW > ROW_COUNT_W) ? RW : ROW_COUNT_W;

	logic [RIW-1:0] row_q;

	// clamp the row count into 1..MAX_ROWS
	always_comb begin
		if (row_count == '0) begin
			rows = RW'(1);
		end else if (XW'(row_count) > XW'(MAX_ROWS)) begin
			rows = RW'(MAX_ROWS);
		end else begin
			rows = RW'(row_count);
		end
	end

	assign elem = STATE_BITS'(state_id);
	assign row  = row_q;
	assign last = ((RW + 1)'(row_q) + (RW + 1)'(1)) >= (RW + 1)'(rows);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (push) begin
			row_q <= last ? '0 : row_q + RIW'(1);
		end
	end
endmodule

// File: src/mcd_back.sv
// back end: stores the column, searches the distinct store and forms the result
// depends on mcd_pkg and mcd_ram
module mcd_back import mcd_pkg::*; #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_GROUPS = 256,
	parameter int STATE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [COL_COUNT_W-1:0] column_count,
	input  logic                   q_empty,
	input  logic [STATE_BITS-1:0]  q_elem,
	input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] q_row,
	input  logic                   q_last,
	input  logic [$clog2(MAX_ROWS + 1)-1:0] q_rows,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mcd_result_t            result
);
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int GIW = $clog2(MAX_GROUPS);
	localparam int TW  = $clog2(MAX_GROUPS + 1);
	localparam int SD  = MAX_GROUPS * MAX_ROWS;
	localparam int AW  = $clog2(SD);

	localparam logic [1:0] ST_COLLECT = 2'd0;
	localparam logic [1:0] ST_READ    = 2'd1;
	localparam logic [1:0] ST_CMP     = 2'd2;
	localparam logic [1:0] ST_DECIDE  = 2'd3;

	logic [1:0]            state_q;
	logic [GIW-1:0]        g_q;
	logic [RIW-1:0]        r_q;
	logic [RW-1:0]         rows_q;
	logic [TW-1:0]         total_q;
	logic [7:0]            col_q;
	logic                  found_q;
	logic                  out_valid_q;
	mcd_result_t           res_q;

	logic                  store_we;
	logic [AW-1:0]         store_waddr;
	logic [AW-1:0]         store_raddr;
	logic [STATE_BITS-1:0] buf_rdata;
	logic [STATE_BITS-1:0] store_rdata;
	logic [COL_COUNT_W-1:0] cols;
	logic                  last_g;
	logic                  last_r;
	logic                  load;
	logic                  is_new;
	logic                  full;
	logic                  done;
	logic [TW-1:0]         next_total;
	logic [GIW-1:0]        group;

	assign q_pop       = (state_q == ST_COLLECT) && !q_empty;
	assign store_we    = q_pop && (total_q < TW'(MAX_GROUPS));
	assign store_waddr = AW'(total_q[GIW-1:0]) * AW'(MAX_ROWS) + AW'(q_row);
	assign store_raddr = AW'(g_q) * AW'(MAX_ROWS) + AW'(r_q);

	mcd_ram #(.WIDTH(STATE_BITS), .DEPTH(MAX_ROWS)) u_col_buf (
		.clk   (clk),
		.we    (q_pop),
		.waddr (q_row),
		.wdata (q_elem),
		.raddr (r_q),
		.rdata (buf_rdata)
	);

	mcd_ram #(.WIDTH(STATE_BITS), .DEPTH(SD)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (q_elem),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	always_comb begin
		if (column_count == '0) begin
			cols = COL_COUNT_W'(1);
		end else if (column_count > COL_COUNT_W'(256)) begin
			cols = COL_COUNT_W'(256);
		end else begin
			cols = column_count;
		end
	end

	assign last_g = (TW'(g_q) + TW'(1)) == total_q;
	assign last_r = ((RW + 1)'(r_q) + (RW + 1)'(1)) == (RW + 1)'(rows_q);
	assign load   = (state_q == ST_DECIDE) && (!out_valid_q || out_ready);
	assign is_new = !found_q;
	assign full   = (total_q >= TW'(MAX_GROUPS));
	assign done   = (COL_COUNT_W'(col_q) + COL_COUNT_W'(1)) >= cols;

	always_comb begin
		next_total = total_q;
		group      = g_q;
		if (is_new) begin
			if (full) begin
				group = GIW'(MAX_GROUPS - 1);
			end else begin
				group      = total_q[GIW-1:0];
				next_total = total_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.group_id       <= 8'(group);
			res_q.is_new         <= is_new;
			res_q.distinct_count <= 9'(next_total);
			res_q.overflow       <= is_new && full;
			res_q.matrix_done    <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			g_q         <= '0;
			r_q         <= '0;
			rows_q      <= RW'(1);
			total_q     <= '0;
			col_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (q_pop && q_last) begin
						rows_q  <= q_rows;
						g_q     <= '0;
						r_q     <= '0;
						found_q <= 1'b0;
						state_q <= (total_q == '0) ? ST_DECIDE : ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (buf_rdata != store_rdata) begin
						r_q <= '0;
						if (last_g) begin
							state_q <= ST_DECIDE;
						end else begin
							g_q     <= g_q + GIW'(1);
							state_q <= ST_READ;
						end
					end else if (last_r) begin
						found_q <= 1'b1;
						state_q <= ST_DECIDE;
					end else begin
						r_q     <= r_q + RIW'(1);
						state_q <= ST_READ;
					end
				end
				ST_DECIDE: begin
					if (load) begin
						state_q <= ST_COLLECT;
						if (done) begin
							col_q   <= '0;
							total_q <= '0;
						end else begin
							col_q   <= col_q + 8'd1;
							total_q <= next_total;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;
endmodule

// File: src/matrix_column_dedup.sv
// top level of the duplicate column elimination block
// depends on mcd_pkg, mcd_front, mcd_queue, mcd_back, mcd_ram and the assert header
//
// usage
//  - input channel in_valid/in_ready carries one state_id item, the next row of the
//    current column; columns are row_count items long
//  - one result item per finished column on out_valid/out_ready: group_id, is_new,
//    distinct_count, overflow and matrix_done; intermediate items give no result
//  - config channel cfg_valid/cfg_ready, cfg_index 0 is row_count, 1 is column_count;
//    always ready, write only while the block is idle
//  - the front takes an item per cycle into a four-entry queue unless it is full;
//    the back, while collecting, drains it one item per cycle into the column
//    buffer and a spare store slot
//  - at the end of a column the back compares against each stored column, row by
//    row via the single store read port (registered store read, then compare),
//    stopping at the first mismatching row; with an empty store it skips the search
//  - the result sits in an output register; a stalled receiver holds the back in
//    its decide step while the front keeps filling the queue until it is full
//  - reset empties the queue, clears counts, row_count to 1 and column_count to
//    256; stores need no clearing as only written entries are compared
`include "matrix_column_dedup_assert.svh"
module matrix_column_dedup import mcd_pkg::*; #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_GROUPS = 256,
	parameter int STATE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           state_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            group_id,
	output logic                  is_new,
	output logic [8:0]            distinct_count,
	output logic                  overflow,
	output logic                  matrix_done
);
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int QW  = STATE_BITS + RIW + 1 + RW;

	logic [ROW_COUNT_W-1:0] row_count_q;
	logic [COL_COUNT_W-1:0] col_count_q;

	logic                   push;
	logic [STATE_BITS-1:0]  f_elem;
	logic [RIW-1:0]         f_row;
	logic                   f_last;
	logic [RW-1:0]          f_rows;
	logic [QW-1:0]          q_dout;
	logic                   q_full;
	logic                   q_empty;
	logic                   q_pop;
	mcd_result_t            result;

	// config registers, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_W'(1);
			col_count_q <= COL_COUNT_W'(256);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data[ROW_COUNT_W-1:0];
				CFG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: an item goes in whenever the queue has room
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	mcd_front #(.MAX_ROWS(MAX_ROWS), .STATE_BITS(STATE_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_count (row_count_q),
		.push      (push),
		.state_id  (state_id),
		.elem      (f_elem),
		.row       (f_row),
		.last      (f_last),
		.rows      (f_rows)
	);

	mcd_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({f_elem, f_row, f_last, f_rows}),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: column store, search and result register
	mcd_back #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_GROUPS (MAX_GROUPS),
		.STATE_BITS (STATE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.column_count (col_count_q),
		.q_empty      (q_empty),
		.q_elem       (q_dout[QW-1 -: STATE_BITS]),
		.q_row        (q_dout[RW+1 +: RIW]),
		.q_last       (q_dout[RW]),
		.q_rows       (q_dout[RW-1:0]),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result       (result)
	);

	assign group_id       = result.group_id;
	assign is_new         = result.is_new;
	assign distinct_count = result.distinct_count;
	assign overflow       = result.overflow;
	assign matrix_done    = result.matrix_done;

	// a freshly stored column takes the last number handed out
	`MCD_ASSERT(a_new_group_number,
		out_valid && is_new && !overflow |-> 9'(group_id) == distinct_count - 9'd1,
		"new column number does not match distinct count")
	// overflow only when the store is full
	`MCD_ASSERT(a_overflow_full,
		out_valid && overflow |-> is_new && distinct_count == 9'(MAX_GROUPS),
		"overflow without a full store")
	// a repeated column points at an already stored column
	`MCD_ASSERT(a_old_group_stored,
		out_valid && !is_new |-> 9'(group_id) < distinct_count,
		"repeated column refers to an unstored group")
endmodule

// File: tb/tb_matrix_column_dedup.sv
// testbench for matrix_column_dedup: streams state matrices column by column and
// checks every column result against an in-bench model of the dedup store
// depends on mcd_pkg and the matrix_column_dedup rtl
`timescale 1ns / 100ps

class column_dedup_scoreboard;
	// register copies, kept raw as written
	bit [6:0]  rows_raw;
	bit [8:0]  cols_raw;
	// model state
	bit [15:0] col_buf [64];
	bit [15:0] groups [256*64];
	int unsigned stored;
	int unsigned row_pos;
	int unsigned col_pos;
	mcd_pkg::mcd_result_t expected_results [$];
	int errors;

	function void reset_state();
		rows_raw = 1;
		cols_raw = 256;
		stored = 0;
		row_pos = 0;
		col_pos = 0;
		expected_results.delete();
		errors = 0;
	endfunction

	function int unsigned eff_rows();
		if (rows_raw == 0) return 1;
		if (rows_raw > 64) return 64;
		return rows_raw;
	endfunction

	function int unsigned eff_cols();
		if (cols_raw == 0) return 1;
		if (cols_raw > 256) return 256;
		return cols_raw;
	endfunction

	function void write_reg(logic idx, bit [8:0] data);
		if (idx == mcd_pkg::CFG_ROW_COUNT) begin
			rows_raw = data[6:0];
		end else begin
			cols_raw = data;
		end
	endfunction

	// one accepted state id; a finished column adds one expected result
	function void note_item(bit [15:0] sid);
		int unsigned rows;
		int unsigned g;
		bit hit;
		bit same;
		mcd_pkg::mcd_result_t r;
		rows = eff_rows();
		hit = 0;
		if (row_pos < 64) col_buf[row_pos] = sid;
		if (row_pos + 1 < rows) begin
			row_pos++;
			return;
		end
		row_pos = 0;
		r = '0;
		for (g = 0; g < stored && g < 256 && !hit; g++) begin
			same = 1;
			for (int unsigned k = 0; k < rows; k++)
				if (groups[g*64+k] != col_buf[k]) same = 0;
			if (same) begin
				hit = 1;
				r.group_id = g[7:0];
			end
		end
		if (!hit) begin
			r.is_new = 1;
			if (stored >= 256) begin
				r.overflow = 1;
				r.group_id = 8'd255;
			end else begin
				r.group_id = stored[7:0];
				for (int unsigned k = 0; k < rows; k++) groups[stored*64+k] = col_buf[k];
				stored++;
			end
		end
		r.distinct_count = stored[8:0];
		r.matrix_done = (col_pos + 1 >= eff_cols());
		if (r.matrix_done) begin
			col_pos = 0;
			stored = 0;
		end else begin
			col_pos++;
		end
		expected_results.insert(expected_results.size(), r);
	endfunction

	function void check_result(mcd_pkg::mcd_result_t got);
		mcd_pkg::mcd_result_t exp_r;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result item, actual %p", $time, got);
			errors++;
			return;
		end
		exp_r = expected_results.pop_front();
		if (got.group_id != exp_r.group_id) begin
			$display("%0t: group_id expected %0d actual %0d", $time,
				exp_r.group_id, got.group_id);
			errors++;
		end
		if (got.is_new != exp_r.is_new) begin
			$display("%0t: is_new expected %0d actual %0d", $time, exp_r.is_new, got.is_new);
			errors++;
		end
		if (got.distinct_count != exp_r.distinct_count) begin
			$display("%0t: distinct_count expected %0d actual %0d", $time,
				exp_r.distinct_count, got.distinct_count);
			errors++;
		end
		if (got.overflow != exp_r.overflow) begin
			$display("%0t: overflow expected %0d actual %0d", $time,
				exp_r.overflow, got.overflow);
			errors++;
		end
		if (got.matrix_done != exp_r.matrix_done) begin
			$display("%0t: matrix_done expected %0d actual %0d", $time,
				exp_r.matrix_done, got.matrix_done);
			errors++;
		end
	endfunction
endclass

module tb_matrix_column_dedup;
	import mcd_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [15:0]           state_id;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            group_id;
	logic                  is_new;
	logic [8:0]            distinct_count;
	logic                  overflow;
	logic                  matrix_done;

	column_dedup_scoreboard sb;
	int sender_idle;     // percent of cycles the sender holds back
	int receiver_idle;   // percent of cycles the receiver stalls
	int items_sent;
	bit hold_request;    // asks the receiver for one long stall
	bit [15:0] patterns [4][64];

	matrix_column_dedup dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .state_id(state_id),
		.out_valid(out_valid), .out_ready(out_ready), .group_id(group_id),
		.is_new(is_new), .distinct_count(distinct_count), .overflow(overflow),
		.matrix_done(matrix_done)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// idling schedule follows the running item count
	function void update_idling();
		if (items_sent < 450) begin
			sender_idle = 30;
			receiver_idle = 51;
		end else if (items_sent < 900) begin
			sender_idle = 51;
			receiver_idle = 30;
		end else begin
			sender_idle = 0;
			receiver_idle = 0;
		end
	endfunction

	// offer one state id; each cycle the sender may idle before offering it
	task automatic send_state(input bit [15:0] v);
		while ($urandom_range(0, 99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		state_id <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(v);
		items_sent++;
		update_idling();
	endtask

	// register write only once the block has gone quiet
	task automatic write_reg(input logic idx, input bit [8:0] data);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	function bit [15:0] random_state();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// whole matrices of random columns; many repeat one of four patterns
	task automatic random_matrices(input int n_mat);
		int unsigned rows;
		int unsigned cols;
		int p;
		rows = sb.eff_rows();
		cols = sb.eff_cols();
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 64; k++) patterns[i][k] = random_state();
		repeat (n_mat * cols) begin
			p = $urandom_range(0, 9);
			for (int unsigned k = 0; k < rows; k++) begin
				if (p < 6) send_state(patterns[p % 4][k]);
				else send_state(random_state());
			end
		end
	endtask

	// receiver: checks accepted results, stalls at random and on request for a long stretch
	initial begin
		int hold_left;
		mcd_result_t got;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.group_id = group_id;
				got.is_new = is_new;
				got.distinct_count = distinct_count;
				got.overflow = overflow;
				got.matrix_done = matrix_done;
				sb.check_result(got);
			end
			if (hold_request) begin
				hold_request = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= receiver_idle);
			end
		end
	end

	// watchdog
	initial begin
		#30ms;
		$display("[matrix_column_dedup] ERROR");
		$finish;
	end

	initial begin
		int unsigned r;
		int unsigned c;
		sb = new();
		sb.reset_state();
		items_sent = 0;
		hold_request = 0;
		update_idling();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ROW_COUNT;
		cfg_data = '0;
		in_valid = 1'b0;
		state_id = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one row, 256 columns, all distinct so the count reaches 256
		for (int i = 0; i < 256; i++) send_state({i[7:0], ~i[7:0]});

		// zero in both registers acts as one row, one column per matrix
		write_reg(CFG_ROW_COUNT, 9'd0);
		write_reg(CFG_COL_COUNT, 9'd0);
		for (int i = 0; i < 6; i++) send_state(random_state());

		// two rows, four columns: new, new, repeat, partly matching
		write_reg(CFG_ROW_COUNT, 9'h182);
		write_reg(CFG_COL_COUNT, 9'd4);
		send_state(16'h0000); send_state(16'h0000);
		send_state(16'hffff); send_state(16'hffff);
		send_state(16'h0000); send_state(16'h0000);
		send_state(16'hffff); send_state(16'h0000);

		// row count above range acts as the full 64, column count above range as 256
		write_reg(CFG_ROW_COUNT, 9'd127);
		write_reg(CFG_COL_COUNT, 9'd2);
		hold_request = 1;   // long receiver stall while the input keeps offering items
		random_matrices(2);
		write_reg(CFG_ROW_COUNT, 9'd1);
		write_reg(CFG_COL_COUNT, 9'h1ff);
		random_matrices(1);

		// random settings, mostly small
		while (items_sent < 1300) begin
			if ($urandom_range(0, 5) == 0) begin
				r = $urandom_range(8, 64);
				c = $urandom_range(1, 4);
			end else begin
				r = $urandom_range(1, 6);
				c = $urandom_range(1, 12);
			end
			write_reg(CFG_ROW_COUNT, r[8:0]);
			write_reg(CFG_COL_COUNT, c[8:0]);
			if ($urandom_range(0, 7) == 0) hold_request = 1;
			random_matrices($urandom_range(1, 3));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[matrix_column_dedup] OK");
		end else begin
			$display("[matrix_column_dedup] ERROR");
		end
		$finish;
	end
endmodule
